// File: sv/cmmr_pkg.sv
// Shared types and constants of the conditional min-max rescaler.
// Used by cmmr_divider and conditional_min_max_rescaler; depends on nothing.
`default_nettype none

package cmmr_pkg;

   localparam int DefaultBatchDepth = 64;

   localparam int DATA_W = 32;
   localparam int MAG_W  = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W;

   // The quotient never exceeds the range magnitude (33 bits); round up to a
   // whole number of divider steps.
   localparam int QUOT_W     = 36;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam logic signed [DATA_W-1:0] RANGE_LOWER_RESET = -32'sd65536;
   localparam logic signed [DATA_W-1:0] RANGE_UPPER_RESET = 32'sd65536;
   localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_LOWER = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_UPPER = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

// File: sv/cmmr_divider.sv
// Iterative unsigned divider: 64-bit dividend by 32-bit divisor, 4 quotient
// bits per cycle. Depends on cmmr_pkg.
`default_nettype none

module cmmr_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmmr_pkg::div_req_type div_req,
   output cmmr_pkg::div_rsp_type      div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [cmmr_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [cmmr_pkg::DATA_W-1:0]        rem_ff, rem_in;
   logic [cmmr_pkg::DATA_W-1:0]        div_ff, div_in;
   logic [cmmr_pkg::QUOT_W-1:0]        shift_ff, shift_in;

   always_comb begin
      logic [cmmr_pkg::DATA_W:0]   trial;
      logic                        ge;
      logic [cmmr_pkg::DATA_W-1:0] rem_v;
      logic [cmmr_pkg::QUOT_W-1:0] shift_v;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_v   = rem_ff;
      shift_v = shift_ff;
      trial   = '0;
      ge      = 1'b0;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         div_in  = div_req.divisor;
         rem_v   = cmmr_pkg::DATA_W'(
                      div_req.dividend[cmmr_pkg::PROD_W-1:cmmr_pkg::QUOT_W]);
         shift_v = div_req.dividend[cmmr_pkg::QUOT_W-1:0];
      end else if (busy_ff) begin
         // restoring steps; quotient bits shift in from the bottom
         for (int s = 0; s < cmmr_pkg::DIV_STEPS; s++) begin
            trial   = {rem_v, shift_v[cmmr_pkg::QUOT_W-1]};
            ge      = trial >= {1'b0, div_ff};
            rem_v   = ge ? cmmr_pkg::DATA_W'(trial - {1'b0, div_ff})
                         : trial[cmmr_pkg::DATA_W-1:0];
            shift_v = {shift_v[cmmr_pkg::QUOT_W-2:0], ge};
         end
         if (cnt_ff == cmmr_pkg::DIV_CNT_W'(cmmr_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end

      rem_in   = rem_v;
      shift_in = shift_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      shift_ff <= shift_in;
   end

   assign div_rsp = {done_ff, shift_ff[cmmr_pkg::MAG_W-1:0]};

endmodule

`default_nettype wire

// File: sv/conditional_min_max_rescaler.sv
// Conditional min-max rescaler: collects a batch of Q16.16 samples and emits
// it unchanged or rescaled into [range_lower, range_upper].
// Uses cmmr_pkg and cmmr_divider.
//
// Usage:
//   The request channel (req_*) takes one sample per cycle while loading.
//   A request with req_sample_last ends the batch; the whole batch is then
//   emitted on the response channel (rsp_*) in arrival order, the final one
//   marked by rsp_result_last. Samples beyond BATCH_DEPTH are dropped.
//   req_stall is high from the last request until the final response has
//   been placed in the output register.
//   Emission per response: a sample memory read when the batch is passed
//   through; when it is rescaled, the sample memory read, one multiply, then
//   the shared divider at 4 quotient bits per cycle, then the offset and
//   saturation.
//   A stalled response holds in the output register; the next response
//   waits until that register is taken. Loading of the next batch starts
//   while the final response may still wait.
//   Reset (synchronous) clears the batch and sets range_lower to -1.0 and
//   range_upper to +1.0. csr_* writes take effect at once; write only while
//   no batch is being emitted.
`default_nettype none

module conditional_min_max_rescaler #(
   parameter int BATCH_DEPTH = cmmr_pkg::DefaultBatchDepth
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [cmmr_pkg::DATA_W-1:0]  req_sample_value,
   input  wire logic                                req_sample_last,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [cmmr_pkg::DATA_W-1:0]       rsp_scaled_value,
   output logic signed [cmmr_pkg::DATA_W-1:0]       rsp_batch_minimum,
   output logic signed [cmmr_pkg::DATA_W-1:0]       rsp_batch_maximum,
   output logic                                     rsp_scaling_applied,
   output logic                                     rsp_result_last,

   input  wire logic                                csr_wr_en,
   input  wire logic [cmmr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [cmmr_pkg::DATA_W-1:0]         csr_wr_data
);

   localparam int ADDR_W = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BATCH_DEPTH + 1);
   localparam int DW     = cmmr_pkg::DATA_W;
   localparam int MW     = cmmr_pkg::MAG_W;

   cmmr_pkg::state_type         state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [ADDR_W-1:0]           idx_ff, idx_in;
   logic signed [DW-1:0]        min_ff, min_in;
   logic signed [DW-1:0]        max_ff, max_in;
   logic                        oor_ff, oor_in;
   logic signed [DW-1:0]        val_ff, val_in;
   logic signed [DW-1:0]        lower_ff, upper_ff;

   logic [DW-1:0]               sample_mem [BATCH_DEPTH];
   logic [DW-1:0]               rd_data_ff;
   logic                        mem_we;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic signed [DW-1:0]        rsp_value_ff, rsp_min_ff, rsp_max_ff;
   logic                        rsp_scaled_ff, rsp_last_ff;

   cmmr_pkg::div_req_type       div_req;
   cmmr_pkg::div_rsp_type       div_rsp;
   logic                        div_start;

   logic                        accept;
   logic                        slot_free;
   logic                        idx_is_last;
   logic [DW:0]                 dx_full, den_full;
   logic [DW-1:0]               dx, den;
   logic signed [DW:0]          range_diff;
   logic                        range_neg;
   logic [MW-1:0]               range_mag;
   logic [2*DW:0]               prod_full;
   logic signed [DW+1:0]        offset_sum;
   logic signed [DW-1:0]        scaled_sat;

   assign accept      = req_valid && !req_stall;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_is_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // scaling datapath: x - min and max - min are nonnegative and fit 32 bits
   assign dx_full    = {rd_data_ff[DW-1], rd_data_ff} - {min_ff[DW-1], min_ff};
   assign den_full   = {max_ff[DW-1], max_ff} - {min_ff[DW-1], min_ff};
   assign dx         = dx_full[DW-1:0];
   assign den        = (den_full[DW-1:0] == '0) ? DW'(1) : den_full[DW-1:0];
   assign range_diff = {upper_ff[DW-1], upper_ff} - {lower_ff[DW-1], lower_ff};
   assign range_neg  = range_diff[DW];
   assign range_mag  = range_neg ? MW'(-range_diff) : MW'(range_diff);
   assign prod_full  = (2*DW+1)'(dx) * (2*DW+1)'(range_mag);

   assign div_req = {div_start, prod_full[2*DW-1:0], den};

   assign offset_sum = {{2{lower_ff[DW-1]}}, lower_ff}
                     + (range_neg ? -(DW+2)'(div_rsp.quotient)
                                  :  (DW+2)'(div_rsp.quotient));

   // saturate when the top three bits disagree
   always_comb begin
      if (offset_sum[DW+1:DW-1] == 3'b000 || offset_sum[DW+1:DW-1] == 3'b111) begin
         scaled_sat = offset_sum[DW-1:0];
      end else if (offset_sum[DW+1]) begin
         scaled_sat = cmmr_pkg::SAMPLE_MIN;
      end else begin
         scaled_sat = cmmr_pkg::SAMPLE_MAX;
      end
   end

   cmmr_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      oor_in        = oor_ff;
      val_in        = val_ff;
      mem_we        = 1'b0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = 1'b1;

      case (state_ff)
         cmmr_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (accept) begin
               // drop samples once the store is full
               if (count_ff < CNT_W'(BATCH_DEPTH)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (req_sample_value < min_ff) begin
                     min_in = req_sample_value;
                  end
                  if (req_sample_value > max_ff) begin
                     max_in = req_sample_value;
                  end
                  if (req_sample_value < lower_ff || req_sample_value > upper_ff) begin
                     oor_in = 1'b1;
                  end
               end
               if (req_sample_last) begin
                  idx_in   = '0;
                  state_in = cmmr_pkg::ST_READ;
               end
            end
         end
         cmmr_pkg::ST_READ: begin
            state_in = cmmr_pkg::ST_MUL;
         end
         cmmr_pkg::ST_MUL: begin
            if (oor_ff) begin
               div_start = 1'b1;
               state_in  = cmmr_pkg::ST_DIV;
            end else begin
               val_in   = rd_data_ff;
               state_in = cmmr_pkg::ST_OUT;
            end
         end
         cmmr_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               val_in   = scaled_sat;
               state_in = cmmr_pkg::ST_OUT;
            end
         end
         cmmr_pkg::ST_OUT: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (idx_is_last) begin
                  count_in = '0;
                  min_in   = cmmr_pkg::SAMPLE_MAX;
                  max_in   = cmmr_pkg::SAMPLE_MIN;
                  oor_in   = 1'b0;
                  state_in = cmmr_pkg::ST_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = cmmr_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = cmmr_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cmmr_pkg::ST_LOAD;
         count_ff     <= '0;
         idx_ff       <= '0;
         min_ff       <= cmmr_pkg::SAMPLE_MAX;
         max_ff       <= cmmr_pkg::SAMPLE_MIN;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         oor_ff       <= oor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= cmmr_pkg::RANGE_LOWER_RESET;
         upper_ff <= cmmr_pkg::RANGE_UPPER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            cmmr_pkg::CSR_RANGE_LOWER: lower_ff <= csr_wr_data;
            cmmr_pkg::CSR_RANGE_UPPER: upper_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // sample store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[count_ff[ADDR_W-1:0]] <= req_sample_value;
      end
      rd_data_ff <= sample_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= val_ff;
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_scaled_ff <= oor_ff;
         rsp_last_ff   <= idx_is_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_scaled_value    = rsp_value_ff;
   assign rsp_batch_minimum   = rsp_min_ff;
   assign rsp_batch_maximum   = rsp_max_ff;
   assign rsp_scaling_applied = rsp_scaled_ff;
   assign rsp_result_last     = rsp_last_ff;

   a_last_starts_emit: assert property (@(posedge clock) disable iff (reset)
      accept && req_sample_last |=> state_ff == cmmr_pkg::ST_READ)
      else $error("last request did not start emission");

   a_final_clears_batch: assert property (@(posedge clock) disable iff (reset)
      state_ff == cmmr_pkg::ST_OUT && slot_free && idx_is_last
      |=> state_ff == cmmr_pkg::ST_LOAD && count_ff == '0 && rsp_valid && rsp_result_last)
      else $error("final response did not close the batch");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == cmmr_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_div_only_scaling: assert property (@(posedge clock) disable iff (reset)
      state_ff == cmmr_pkg::ST_DIV |-> oor_ff)
      else $error("divide on a pass-through batch");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff != cmmr_pkg::ST_LOAD |-> count_ff != '0)
      else $error("emission with an empty batch");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for conditional_min_max_rescaler: drives sample batches, predicts every
// response from its own copy of the batch state and checks the response stream.
// Depends on cmmr_pkg and the rescaler RTL.

module tb_top;

   localparam int BatchDepth  = cmmr_pkg::DefaultBatchDepth;
   localparam int DrainCycles = 40;
   localparam int DW          = cmmr_pkg::DATA_W;

   typedef enum int {FILL_INSIDE, FILL_ANY, FILL_MIXED, FILL_FLAT} fill_type;

   typedef struct {
      logic signed [DW-1:0] value;
      logic                 last;
   } sample_type;

   typedef struct {
      logic signed [DW-1:0] scaled;
      logic signed [DW-1:0] minimum;
      logic signed [DW-1:0] maximum;
      logic                 applied;
      logic                 last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [DW-1:0] req_sample_value = '0;
   logic                 req_sample_last = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_scaled_value;
   logic signed [DW-1:0] rsp_batch_minimum;
   logic signed [DW-1:0] rsp_batch_maximum;
   logic                 rsp_scaling_applied;
   logic                 rsp_result_last;

   logic                                 csr_wr_en = 1'b0;
   logic [cmmr_pkg::CSR_INDEX_W-1:0]     csr_index = cmmr_pkg::CSR_RANGE_LOWER;
   logic [DW-1:0]                        csr_wr_data = '0;

   // predicted block state
   logic signed [DW-1:0] range_lo = cmmr_pkg::RANGE_LOWER_RESET;
   logic signed [DW-1:0] range_hi = cmmr_pkg::RANGE_UPPER_RESET;
   logic signed [DW-1:0] stored_samples [BatchDepth];
   int                   stored_count = 0;
   logic signed [DW-1:0] batch_min = cmmr_pkg::SAMPLE_MAX;
   logic signed [DW-1:0] batch_max = cmmr_pkg::SAMPLE_MIN;
   logic                 outside_seen = 1'b0;

   sample_type  sample_queue[$];
   outcome_type outputs_due[$];

   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic req_taken = 1'b0;
   int   error_count = 0;

   conditional_min_max_rescaler #(
      .BATCH_DEPTH(BatchDepth)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .req_sample_last    (req_sample_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scaled_value   (rsp_scaled_value),
      .rsp_batch_minimum  (rsp_batch_minimum),
      .rsp_batch_maximum  (rsp_batch_maximum),
      .rsp_scaling_applied(rsp_scaling_applied),
      .rsp_result_last    (rsp_result_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [DW-1:0] got,
                              input logic [DW-1:0] want);
      if (got !== want)
         report_error($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
   endtask

   // lower + (x - min) * (upper - lower) / (max - min), truncated, then saturated
   function automatic logic signed [DW-1:0] rescale_sample(
      input logic signed [DW-1:0] x, mn, mx, lo, hi);
      longint unsigned offset, divisor, span_mag, quotient;
      longint          span, sum;
      offset   = longint'(x) - longint'(mn);
      divisor  = longint'(mx) - longint'(mn);
      span     = longint'(hi) - longint'(lo);
      span_mag = (span < 0) ? -span : span;
      if (divisor == 0)
         divisor = 1;
      quotient = (offset * span_mag) / divisor;
      sum = (span < 0) ? longint'(lo) - longint'(quotient) : longint'(lo) + longint'(quotient);
      if (sum > longint'(cmmr_pkg::SAMPLE_MAX))
         sum = longint'(cmmr_pkg::SAMPLE_MAX);
      if (sum < longint'(cmmr_pkg::SAMPLE_MIN))
         sum = longint'(cmmr_pkg::SAMPLE_MIN);
      return DW'(sum);
   endfunction

   // fold one accepted request into the batch; on the last one queue the whole batch
   function automatic void absorb_sample(input logic signed [DW-1:0] x, input logic last);
      outcome_type res;
      if (stored_count < BatchDepth) begin
         stored_samples[stored_count] = x;
         stored_count++;
         if (x < batch_min)
            batch_min = x;
         if (x > batch_max)
            batch_max = x;
         if (x < range_lo || x > range_hi)
            outside_seen = 1'b1;
      end
      if (!last)
         return;
      for (int i = 0; i < stored_count; i++) begin
         res.scaled  = outside_seen ?
                       rescale_sample(stored_samples[i], batch_min, batch_max, range_lo, range_hi)
                       : stored_samples[i];
         res.minimum = batch_min;
         res.maximum = batch_max;
         res.applied = outside_seen;
         res.last    = (i == stored_count - 1);
         outputs_due = {outputs_due, res};
      end
      stored_count = 0;
      batch_min    = cmmr_pkg::SAMPLE_MAX;
      batch_max    = cmmr_pkg::SAMPLE_MIN;
      outside_seen = 1'b0;
   endfunction

   // request driver: advance only after the current request was taken
   always @(negedge clock) begin : drive_requests
      sample_type nxt;
      if (!req_valid || req_taken) begin
         if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = sample_queue.pop_front();
            req_valid        <= 1'b1;
            req_sample_value <= nxt.value;
            req_sample_last  <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // response monitor and request predictor
   always @(posedge clock) begin : watch_handshakes
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (outputs_due.size() == 0) begin
               report_error($sformatf("unexpected response value 0x%08h", rsp_scaled_value));
            end else begin
               want = outputs_due.pop_front();
               check_field("scaled_value", rsp_scaled_value, want.scaled);
               check_field("batch_minimum", rsp_batch_minimum, want.minimum);
               check_field("batch_maximum", rsp_batch_maximum, want.maximum);
               check_field("scaling_applied", DW'(rsp_scaling_applied), DW'(want.applied));
               check_field("result_last", DW'(rsp_result_last), DW'(want.last));
            end
         end
         if (req_valid && !req_stall)
            absorb_sample(req_sample_value, req_sample_last);
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   task automatic add_sample(input logic signed [DW-1:0] value, input logic last);
      sample_type s;
      s.value = value;
      s.last  = last;
      sample_queue = {sample_queue, s};
   endtask

   function automatic logic signed [DW-1:0] pick_sample(input fill_type fill);
      longint          span;
      longint unsigned draw;
      if (fill == FILL_ANY || range_lo > range_hi ||
          (fill == FILL_MIXED && $urandom_range(3) == 0)) begin
         case ($urandom_range(15))
            0: return cmmr_pkg::SAMPLE_MIN;
            1: return cmmr_pkg::SAMPLE_MAX;
            default: return $urandom;
         endcase
      end
      span = longint'(range_hi) - longint'(range_lo) + 1;
      draw = {$urandom, $urandom};
      return DW'(longint'(range_lo) + longint'(draw % span));
   endfunction

   task automatic queue_batch(input int len, input fill_type fill);
      logic signed [DW-1:0] flat_value;
      flat_value = pick_sample(FILL_MIXED);
      for (int i = 0; i < len; i++)
         add_sample((fill == FILL_FLAT) ? flat_value : pick_sample(fill), i == len - 1);
   endtask

   // hold until every request is taken and every response is back, then let the block settle
   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_valid || outputs_due.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_range(input logic signed [DW-1:0] lo, input logic signed [DW-1:0] hi);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= cmmr_pkg::CSR_RANGE_LOWER;
      csr_wr_data <= lo;
      @(negedge clock);
      csr_index   <= cmmr_pkg::CSR_RANGE_UPPER;
      csr_wr_data <= hi;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      range_lo = lo;
      range_hi = hi;
   endtask

   initial begin : stimulus
      int                   seg_items;
      int                   len;
      int                   guard;
      logic signed [DW-1:0] a, b;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      rsp_stall_pct = 74;

      // reset bounds: pass-through, field extremes, equal extremes, samples on the bounds
      add_sample(0, 1'b1);
      add_sample(cmmr_pkg::SAMPLE_MIN, 1'b0);
      add_sample(cmmr_pkg::SAMPLE_MAX, 1'b0);
      add_sample(0, 1'b1);
      add_sample(32'sh0005_0000, 1'b0);
      add_sample(32'sh0005_0000, 1'b1);
      add_sample(cmmr_pkg::RANGE_LOWER_RESET, 1'b0);
      add_sample(cmmr_pkg::RANGE_UPPER_RESET, 1'b1);
      // range changes in the middle of a batch: test uses old bounds, scaling the new ones
      add_sample(32'sh0002_0000, 1'b0);
      wait_idle();
      set_range(-32'sh0004_0000, 32'sh0004_0000);
      add_sample(32'sh0001_0000, 1'b1);
      // inverted range
      wait_idle();
      set_range(cmmr_pkg::RANGE_UPPER_RESET, cmmr_pkg::RANGE_LOWER_RESET);
      add_sample(0, 1'b0);
      add_sample(100, 1'b0);
      add_sample(200, 1'b1);
      // widest range, then widest inverted range
      wait_idle();
      set_range(cmmr_pkg::SAMPLE_MIN, cmmr_pkg::SAMPLE_MAX);
      add_sample(cmmr_pkg::SAMPLE_MIN, 1'b0);
      add_sample(cmmr_pkg::SAMPLE_MAX, 1'b1);
      wait_idle();
      set_range(cmmr_pkg::SAMPLE_MAX, cmmr_pkg::SAMPLE_MIN);
      add_sample(cmmr_pkg::SAMPLE_MIN, 1'b0);
      add_sample(-1, 1'b0);
      add_sample(cmmr_pkg::SAMPLE_MAX, 1'b1);
      wait_idle();
      set_range(0, 0);
      add_sample(1, 1'b1);

      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         case (seg / 2)
            0: begin
               send_idle_pct = 34;
               rsp_stall_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               rsp_stall_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         a = $urandom;
         b = $urandom;
         case (seg)
            0: set_range(cmmr_pkg::RANGE_LOWER_RESET, cmmr_pkg::RANGE_UPPER_RESET);
            1: set_range((a < b) ? a : b, (a < b) ? b : a);
            3: set_range(0, 32'sh00FF_0000);
            4: set_range(-1, 1);
            default: set_range(a, b);
         endcase
         seg_items = 0;
         // overflow batch: requests past the store depth are dropped, the last one still ends it
         if (seg == 1 || seg == 4) begin
            queue_batch($urandom_range(BatchDepth + 4, BatchDepth + 1), FILL_ANY);
            seg_items += BatchDepth;
         end
         while (seg_items < 57) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(BatchDepth, 9) : $urandom_range(8, 1);
            queue_batch(len, fill_type'($urandom_range(3)));
            seg_items += len;
         end
      end

      while (sample_queue.size() > 0 || req_valid)
         @(posedge clock);
      guard = 0;
      while (outputs_due.size() > 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (outputs_due.size() > 0)
         report_error($sformatf("%0d responses never arrived", outputs_due.size()));
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #40ms;
      $display("status: fail");
      $finish;
   end

endmodule
